// File: hdl/blss_pkg.sv
// shared types and constants of the bounded stack with dump and search
package blss_pkg;

  // fixed field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned CAP_W    = 5;

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // register index carried on paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  // operation of an input beat
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_DUMP   = 2'd2,
    MODE_SEARCH = 2'd3
  } mode_e;

  // status of a result beat
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_e;

  // one result beat
  typedef struct packed {
    status_e              status;
    logic [VALUE_W-1:0]   item_value;
    logic [POS_W-1:0]     position;
    logic [POS_W-1:0]     match_count;
    logic                 found;
    logic                 is_full;
    logic                 is_empty;
    logic                 last;
  } res_t;

endpackage

// File: hdl/blss_mem.sv
// stack entry storage: one write port, one read port, registered read data
module blss_mem #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [31:0]       wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/blss_ctrl.sv
// stack sequencer: fill count, entry walk for dump and search, result register
module blss_ctrl import blss_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command beats
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [MODE_W-1:0]   in_mode_i,
  input  logic [VALUE_W-1:0]  in_value_i,
  // capacity register
  input  logic [CAP_W-1:0]    cap_i,
  // memory ports
  output logic                mem_we_o,
  output logic [AddrW-1:0]    mem_waddr_o,
  output logic [VALUE_W-1:0]  mem_wdata_o,
  output logic                mem_re_o,
  output logic [AddrW-1:0]    mem_raddr_o,
  input  logic [VALUE_W-1:0]  mem_rdata_i,
  // result beats
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output res_t                res_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > POS_W) ? CntW : POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_WALK,
    S_FINAL
  } state_e;

  state_e              state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [VALUE_W-1:0]  key_q, key_d;
  logic [CntW-1:0]     fill_q, fill_d;
  logic [CntW-1:0]     k_q, k_d;
  logic [CntW-1:0]     ptr_q, ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  status_e             pend_status_q, pend_status_d;
  logic [VALUE_W-1:0]  pend_item_q, pend_item_d;
  logic                pend_mem_q, pend_mem_d;
  logic                pend_pos_q, pend_pos_d;
  logic                out_valid_q, out_valid_d;
  res_t                out_q, out_d;

  logic [CmpW-1:0]     cap_ext;
  logic [CmpW-1:0]     eff_cap;
  logic                is_full;
  logic                is_empty;
  logic                slot_free;
  logic [CntW-1:0]     fill_m1;
  logic [CntW-1:0]     ptr_m1;
  logic [CntW-1:0]     k_inc;
  logic                last_elem;
  logic                is_match;
  logic                need_out;

  // effective capacity: zero acts as one, above depth acts as depth
  always_comb begin
    cap_ext = CmpW'(cap_i);
    if (cap_ext == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > CmpW'(DEPTH)) begin
      eff_cap = CmpW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign is_full   = CmpW'(fill_q) >= eff_cap;
  assign is_empty  = (fill_q == '0);
  assign slot_free = !out_valid_q || res_ready_i;
  assign fill_m1   = fill_q - CntW'(1);
  assign ptr_m1    = ptr_q - CntW'(1);
  assign k_inc     = k_q + CntW'(1);
  assign last_elem = (k_inc == fill_q);
  assign is_match  = (mem_rdata_i == key_q);
  assign need_out  = (mode_q == MODE_DUMP) || is_match;

  // next state and memory requests
  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    key_d         = key_q;
    fill_d        = fill_q;
    k_d           = k_q;
    ptr_d         = ptr_q;
    cnt_d         = cnt_q;
    pend_status_d = pend_status_q;
    pend_item_d   = pend_item_q;
    pend_mem_d    = pend_mem_q;
    pend_pos_d    = pend_pos_q;
    out_valid_d   = out_valid_q && !res_ready_i;
    out_d         = out_q;
    in_ready_o    = 1'b0;
    mem_we_o      = 1'b0;
    mem_waddr_o   = fill_q[AddrW-1:0];
    mem_wdata_o   = in_value_i;
    mem_re_o      = 1'b0;
    mem_raddr_o   = fill_m1[AddrW-1:0];

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d        = mode_e'(in_mode_i);
          key_d         = in_value_i;
          k_d           = '0;
          cnt_d         = '0;
          pend_status_d = ST_OK;
          pend_item_d   = '0;
          pend_mem_d    = 1'b0;
          pend_pos_d    = 1'b0;
          state_d       = S_EMIT;
          if (mode_e'(in_mode_i) == MODE_PUSH) begin
            if (is_full) begin
              pend_status_d = ST_OVER;
            end else begin
              mem_we_o    = 1'b1;
              fill_d      = fill_q + CntW'(1);
              pend_item_d = in_value_i;
              pend_pos_d  = 1'b1;
            end
          end else if (is_empty) begin
            pend_status_d = ST_UNDER;
          end else begin
            // top entry read for pop, dump and search alike
            mem_re_o = 1'b1;
            if (mode_e'(in_mode_i) == MODE_POP) begin
              fill_d     = fill_m1;
              pend_mem_d = 1'b1;
              pend_pos_d = 1'b1;
            end else begin
              ptr_d   = fill_m1;
              state_d = S_WALK;
            end
          end
        end
      end

      // single result of push, pop, overflow or underflow
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d.status      = pend_status_q;
          out_d.item_value  = pend_mem_q ? mem_rdata_i : pend_item_q;
          out_d.position    = pend_pos_q ? POS_W'(1) : '0;
          out_d.match_count = '0;
          out_d.found       = 1'b0;
          out_d.is_full     = is_full;
          out_d.is_empty    = is_empty;
          out_d.last        = 1'b1;
          state_d           = S_IDLE;
        end
      end

      // one entry per cycle from the top, stalls only when a beat is due
      S_WALK: begin
        if (!need_out || slot_free) begin
          if (need_out) begin
            out_valid_d       = 1'b1;
            out_d.status      = ST_OK;
            out_d.item_value  = mem_rdata_i;
            out_d.position    = POS_W'(CmpW'(k_inc));
            out_d.match_count = '0;
            out_d.found       = 1'b0;
            out_d.is_full     = is_full;
            out_d.is_empty    = is_empty;
            out_d.last        = (mode_q == MODE_DUMP) && last_elem;
          end
          if ((mode_q == MODE_SEARCH) && is_match) begin
            cnt_d = cnt_q + CntW'(1);
          end
          if (last_elem) begin
            state_d = (mode_q == MODE_DUMP) ? S_IDLE : S_FINAL;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = ptr_m1[AddrW-1:0];
            ptr_d       = ptr_m1;
            k_d         = k_inc;
          end
        end
      end

      // closing search beat with the match count
      S_FINAL: begin
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d.status      = ST_OK;
          out_d.item_value  = '0;
          out_d.position    = '0;
          out_d.match_count = POS_W'(CmpW'(cnt_q));
          out_d.found       = (cnt_q != '0);
          out_d.is_full     = is_full;
          out_d.is_empty    = is_empty;
          out_d.last        = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    mode_q        <= mode_d;
    key_q         <= key_d;
    k_q           <= k_d;
    ptr_q         <= ptr_d;
    cnt_q         <= cnt_d;
    pend_status_q <= pend_status_d;
    pend_item_q   <= pend_item_d;
    pend_mem_q    <= pend_mem_d;
    pend_pos_q    <= pend_pos_d;
    out_q         <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// File: hdl/bounded_lifo_stack_search_top.sv
// top level of the bounded stack with dump and search
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata value, tuser mode
//  m_axis    out  m_axis_tvalid/tready      tdata result fields, tuser status, tlast
//  apb       in   psel/penable, pready=1    capacity at byte address 0
//
// push, pop, overflow and underflow pass through the emit state before the next accept.
// the entry memory has registered read data, which the dump and search walk covers by
// reading the next entry while the current one is emitted. a result waiting in the
// output register does not block the next command beat; the walk pauses only when a
// beat is due and the register is still full. reset clears the fill count, no entries
// are held, capacity returns to 16.
module bounded_lifo_stack_search_top import blss_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // command beats
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [31:0] value
  input  logic [1:0]   s_axis_tuser,   // [1:0] mode
  // result beats
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,   // [31:0] item_value, [36:32] position,
                                       // [41:37] match_count, [42] found,
                                       // [43] is_full, [44] is_empty, [47:45] zero
  output logic [1:0]   m_axis_tuser,   // [1:0] status
  output logic         m_axis_tlast,   // last
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CAP_W-1:0]    cap_q;
  logic                cfg_wr;
  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr;
  logic [VALUE_W-1:0]  mem_wdata;
  logic                mem_re;
  logic [AddrW-1:0]    mem_raddr;
  logic [VALUE_W-1:0]  mem_rdata;
  res_t                res;

  // capacity register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - CAP_W){1'b0}}, cap_q} : '0;

  // sequencer
  blss_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser),
    .in_value_i  (s_axis_tdata),
    .cap_i       (cap_q),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // entry memory
  blss_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // result beat packing
  assign m_axis_tdata = {3'b000, res.is_empty, res.is_full, res.found,
                         res.match_count, res.position, res.item_value};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

  // a command beat always leaves the sequencer busy in the cycle after it is accepted
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command accepted in the cycle after a command beat");

  // effective capacity is at least one, so full and empty never meet
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[43] && m_axis_tdata[44]))
    else $error("result beat flags full and empty together");

  // overflow is only reported on a full stack, as a single beat
  a_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_OVER) |-> m_axis_tdata[43] && m_axis_tlast)
    else $error("overflow beat without full flag or last");

  // underflow is only reported on an empty stack, with no data
  a_under_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_UNDER)
      |-> m_axis_tdata[44] && m_axis_tlast && (m_axis_tdata[31:0] == 32'd0))
    else $error("underflow beat with data or without empty flag");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of the bounded stack with dump and search
module testbench;
  import blss_pkg::*;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_ITEMS   = 15;

  // directed stimulus row: a command beat, or a capacity write when is_cfg is set
  typedef struct packed {
    bit                 is_cfg;
    bit                 typed;
    mode_e              mode;
    logic [31:0]        value;
    status_e            st;
    logic [31:0]        item;
    logic [POS_W-1:0]   pos;
    logic               full;
    logic               empty;
  } row_t;

  localparam int unsigned N_ROWS = 26;
  localparam row_t DIR_ROWS [N_ROWS] = '{
    // empty stack after reset
    '{1'b0, 1'b1, MODE_POP,    32'h0000_0000, ST_UNDER, 32'h0000_0000, 5'd0, 1'b0, 1'b1},
    '{1'b0, 1'b1, MODE_DUMP,   32'h0000_0000, ST_UNDER, 32'h0000_0000, 5'd0, 1'b0, 1'b1},
    '{1'b0, 1'b1, MODE_SEARCH, 32'h0000_0000, ST_UNDER, 32'h0000_0000, 5'd0, 1'b0, 1'b1},
    // value extremes
    '{1'b0, 1'b1, MODE_PUSH,   32'h7fff_ffff, ST_OK,    32'h7fff_ffff, 5'd1, 1'b0, 1'b0},
    '{1'b0, 1'b1, MODE_PUSH,   32'h8000_0000, ST_OK,    32'h8000_0000, 5'd1, 1'b0, 1'b0},
    '{1'b0, 1'b1, MODE_PUSH,   32'h0000_0000, ST_OK,    32'h0000_0000, 5'd1, 1'b0, 1'b0},
    '{1'b0, 1'b1, MODE_PUSH,   32'hffff_ffff, ST_OK,    32'hffff_ffff, 5'd1, 1'b0, 1'b0},
    '{1'b0, 1'b0, MODE_PUSH,   32'h8000_0000, ST_OK,    32'h0000_0000, 5'd0, 1'b0, 1'b0},
    '{1'b0, 1'b0, MODE_DUMP,   32'h0000_0000, ST_OK,    32'h0000_0000, 5'd0, 1'b0, 1'b0},
    // two matches, then no match
    '{1'b0, 1'b0, MODE_SEARCH, 32'h8000_0000, ST_OK,    32'h0000_0000, 5'd0, 1'b0, 1'b0},
    '{1'b0, 1'b0, MODE_SEARCH, 32'h0001_2345, ST_OK,    32'h0000_0000, 5'd0, 1'b0, 1'b0},
    '{1'b0, 1'b1, MODE_POP,    32'h0000_0000, ST_OK,    32'h8000_0000, 5'd1, 1'b0, 1'b0},
    // capacity lowered below the fill count
    '{1'b1, 1'b0, MODE_PUSH,   32'd2,         ST_OK,    32'h0000_0000, 5'd0, 1'b0, 1'b0},
    '{1'b0, 1'b1, MODE_PUSH,   32'h0000_0005, ST_OVER,  32'h0000_0000, 5'd0, 1'b1, 1'b0},
    '{1'b0, 1'b0, MODE_SEARCH, 32'h0000_0000, ST_OK,    32'h0000_0000, 5'd0, 1'b0, 1'b0},
    '{1'b0, 1'b1, MODE_POP,    32'h0000_0000, ST_OK,    32'hffff_ffff, 5'd1, 1'b1, 1'b0},
    '{1'b0, 1'b1, MODE_POP,    32'h0000_0000, ST_OK,    32'h0000_0000, 5'd1, 1'b1, 1'b0},
    '{1'b0, 1'b1, MODE_POP,    32'h0000_0000, ST_OK,    32'h8000_0000, 5'd1, 1'b0, 1'b0},
    '{1'b0, 1'b1, MODE_PUSH,   32'h0000_0001, ST_OK,    32'h0000_0001, 5'd1, 1'b1, 1'b0},
    '{1'b0, 1'b1, MODE_PUSH,   32'h0000_0002, ST_OVER,  32'h0000_0000, 5'd0, 1'b1, 1'b0},
    // capacity zero acts as one
    '{1'b1, 1'b0, MODE_PUSH,   32'd0,         ST_OK,    32'h0000_0000, 5'd0, 1'b0, 1'b0},
    '{1'b0, 1'b1, MODE_POP,    32'h0000_0000, ST_OK,    32'h0000_0001, 5'd1, 1'b1, 1'b0},
    '{1'b0, 1'b1, MODE_PUSH,   32'h0000_0003, ST_OVER,  32'h0000_0000, 5'd0, 1'b1, 1'b0},
    '{1'b0, 1'b1, MODE_POP,    32'h0000_0000, ST_OK,    32'h7fff_ffff, 5'd1, 1'b0, 1'b1},
    // capacity above depth acts as depth
    '{1'b1, 1'b0, MODE_PUSH,   32'd31,        ST_OK,    32'h0000_0000, 5'd0, 1'b0, 1'b0},
    '{1'b0, 1'b1, MODE_DUMP,   32'h0000_0000, ST_UNDER, 32'h0000_0000, 5'd0, 1'b0, 1'b1}
  };

  localparam logic [CAP_W-1:0] PHASE_CAP [PHASES] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd6, 5'd16};
  localparam int unsigned PUSH_PCT [PHASES] = '{45, 85, 45, 70, 50, 40};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = MODE_PUSH;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // typed-in expectation travelling with the current command beat
  bit   cmd_typed = 1'b0;
  res_t cmd_typed_beat = '0;

  // predicted stack contents and configuration
  logic [31:0]      stack_copy [DEPTH];
  int unsigned      stack_fill = 0;
  logic [CAP_W-1:0] capacity_copy = CAP_RESET;
  res_t             expected_beats [$];

  int unsigned tx_idle_pct = 11;
  int unsigned rx_idle_pct = 67;
  int unsigned n_err = 0;
  int unsigned n_cmds = 0;
  int unsigned n_beats = 0;
  int unsigned n_cfg = 0;
  int unsigned max_burst = 0;
  int unsigned max_fill = 0;
  int unsigned quiet_cycles = 0;

  bounded_lifo_stack_search_top #(.DEPTH(DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // usable capacity after clamping
  function automatic int unsigned usable_capacity();
    if (capacity_copy == '0) return 1;
    if (capacity_copy > DEPTH) return DEPTH;
    return int'(capacity_copy);
  endfunction

  // queue one expected beat with the flags as they stand after the operation
  function automatic void queue_beat(res_t b);
    b.is_full  = (stack_fill >= usable_capacity());
    b.is_empty = (stack_fill == 0);
    expected_beats.push_back(b);
  endfunction

  // expected result beats of one command beat
  function automatic void predict_stack_op(mode_e m, logic [31:0] v);
    res_t        b;
    int unsigned k;
    int unsigned hits;
    int unsigned burst;
    b = '0;
    b.last = 1'b1;
    hits = 0;
    burst = 1;
    if (m == MODE_PUSH) begin
      if (stack_fill >= usable_capacity()) begin
        b.status = ST_OVER;
      end else begin
        stack_copy[stack_fill] = v;
        stack_fill++;
        b.item_value = v;
        b.position = 5'd1;
      end
      queue_beat(b);
    end else if (stack_fill == 0) begin
      b.status = ST_UNDER;
      queue_beat(b);
    end else begin
      case (m)
        MODE_POP: begin
          stack_fill--;
          b.item_value = stack_copy[stack_fill];
          b.position = 5'd1;
          queue_beat(b);
        end
        MODE_DUMP: begin
          for (k = 0; k < stack_fill; k++) begin
            b.item_value = stack_copy[stack_fill - 1 - k];
            b.position = POS_W'(k + 1);
            b.last = (k + 1 == stack_fill);
            queue_beat(b);
          end
          burst = stack_fill;
        end
        default: begin
          b.last = 1'b0;
          for (k = 0; k < stack_fill; k++) begin
            if (stack_copy[stack_fill - 1 - k] == v) begin
              hits++;
              b.item_value = v;
              b.position = POS_W'(k + 1);
              queue_beat(b);
            end
          end
          b = '0;
          b.match_count = POS_W'(hits);
          b.found = (hits != 0);
          b.last = 1'b1;
          queue_beat(b);
          burst = hits + 1;
        end
      endcase
    end
    if (burst > max_burst) max_burst = burst;
    if (stack_fill > max_fill) max_fill = stack_fill;
  endfunction

  // predict at every accepted command beat
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_stack_op(mode_e'(s_axis_tuser), s_axis_tdata);
      if (cmd_typed) begin
        void'(expected_beats.pop_back());
        expected_beats.push_back(cmd_typed_beat);
      end
      n_cmds++;
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0h actual %0h", name, want, got);
      n_err++;
    end
  endfunction

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_beats++;
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: tdata %0h tuser %0h", m_axis_tdata,
               m_axis_tuser);
        n_err++;
      end else begin
        want = expected_beats.pop_front();
        check_field("status", 32'(want.status), 32'(m_axis_tuser));
        check_field("item_value", want.item_value, m_axis_tdata[31:0]);
        check_field("position", 32'(want.position), 32'(m_axis_tdata[36:32]));
        check_field("match_count", 32'(want.match_count), 32'(m_axis_tdata[41:37]));
        check_field("found", 32'(want.found), 32'(m_axis_tdata[42]));
        check_field("is_full", 32'(want.is_full), 32'(m_axis_tdata[43]));
        check_field("is_empty", 32'(want.is_empty), 32'(m_axis_tdata[44]));
        check_field("last", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no beat accepted for %0d cycles, %0d results outstanding", STALL_LIMIT,
               expected_beats.size());
      $display("status: fail");
      $finish;
    end
  end

  // one command beat, with a random gap ahead of it
  task automatic send_cmd(mode_e m, logic [31:0] v, bit typed, res_t tb);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid  <= 1'b1;
    s_axis_tdata   <= v;
    s_axis_tuser   <= m;
    cmd_typed      <= typed;
    cmd_typed_beat <= tb;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // capacity write once the block has drained
  task automatic write_capacity(logic [CAP_W-1:0] c);
    s_axis_tvalid <= 1'b0;
    // let the predictor see the last accepted beat first
    @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= 32'(c);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    capacity_copy = c;
    n_cfg++;
  endtask

  // random value, often one of a few that repeat so searches match
  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: return 32'h0000_0000;
          1: return 32'hffff_ffff;
          2: return 32'h8000_0000;
          default: return 32'h7fff_ffff;
        endcase
      end
      1: return 32'($urandom_range(3));
      default: return $urandom;
    endcase
  endfunction

  // main sequence
  initial begin : main_seq
    int unsigned r;
    int unsigned p;
    int unsigned i;
    mode_e       m;
    logic [31:0] v;
    res_t        tb;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (i = 0; i < N_ROWS; i++) begin
      if (DIR_ROWS[i].is_cfg) begin
        write_capacity(DIR_ROWS[i].value[CAP_W-1:0]);
      end else begin
        tb = '0;
        tb.status   = DIR_ROWS[i].st;
        tb.item_value = DIR_ROWS[i].item;
        tb.position = DIR_ROWS[i].pos;
        tb.is_full  = DIR_ROWS[i].full;
        tb.is_empty = DIR_ROWS[i].empty;
        tb.last     = 1'b1;
        send_cmd(DIR_ROWS[i].mode, DIR_ROWS[i].value, DIR_ROWS[i].typed, tb);
      end
    end

    // random phases, each with its own capacity write, and an idling pattern per pair of phases
    for (p = 0; p < PHASES; p++) begin
      write_capacity(PHASE_CAP[p]);
      case (p / 2)
        0: begin
          tx_idle_pct = 11;
          rx_idle_pct = 67;
        end
        1: begin
          tx_idle_pct = 67;
          rx_idle_pct = 11;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(99);
        if (r < PUSH_PCT[p]) begin
          m = MODE_PUSH;
          v = pick_value();
        end else begin
          case ($urandom_range(2))
            0: m = MODE_POP;
            1: m = MODE_DUMP;
            default: m = MODE_SEARCH;
          endcase
          // search keys mostly taken from the stack
          if (stack_fill != 0 && $urandom_range(3) != 0) begin
            v = stack_copy[$urandom_range(stack_fill - 1)];
          end else begin
            v = pick_value();
          end
        end
        send_cmd(m, v, 1'b0, '0);
      end
    end

    // drain
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("ran %0d commands and %0d result beats across %0d capacity writes",
             n_cmds, n_beats, n_cfg);
    $display("deepest fill %0d, longest burst of results from one command %0d",
             max_fill, max_burst);
    if (n_err == 0 && expected_beats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
